FILE: rtl/sls_pkg.sv
package sls_pkg;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic METHOD_LINEAR = 1'b0;
    localparam logic METHOD_BINARY = 1'b1;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_UNSORTED  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic               method;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] index;
        logic       is_sorted;
        logic [5:0] count;
    } rsp_t;

endpackage

FILE: rtl/sorted_list_search.sv
// Channel  Beat         Handshake
// req      req_t        req_valid / req_stall
// rsp      rsp_t        rsp_valid / rsp_stall
//
// Clear and append take effect in the cycle they are accepted.
// Linear search reads one element per cycle through the single read port.
// Binary search takes one probe per cycle.
// One item in flight; a new item is taken while the previous result still waits in rsp.
// Async active-low reset empties the list; stored elements are not cleared.
module sorted_list_search #(
    parameter int DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sls_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sls_pkg::rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = AW + 5;
    localparam int NW = CW + 6;

    typedef enum logic [1:0] {S_IDLE, S_LIN, S_BIN, S_EMIT} state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               order_reg, order_next;
    logic signed [31:0] last_reg, last_next;
    logic signed [31:0] key_reg, key_next;
    logic [AW-1:0]      probe_reg, probe_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    sls_pkg::rsp_t      res_reg, res_next;
    sls_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    logic               accept;
    logic               slot_free;
    logic               done;
    sls_pkg::rsp_t      done_res;
    logic [CW-1:0]      mid_w;
    logic [CW-1:0]      lo_w;
    logic [CW-1:0]      hi_w;
    logic [CW-1:0]      span_w;

    function automatic sls_pkg::rsp_t pack(input logic [2:0] st, input logic [AW-1:0] idx,
                                           input logic srt, input logic [CW-1:0] cnt);
        logic [IW-1:0] iw;
        logic [NW-1:0] nw;
        sls_pkg::rsp_t r;
        iw          = IW'(idx);
        nw          = NW'(cnt);
        r.status    = st;
        r.index     = iw[4:0];
        r.is_sorted = srt;
        r.count     = nw[5:0];
        return r;
    endfunction

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        order_next     = order_reg;
        last_next      = last_reg;
        key_next       = key_reg;
        probe_next     = probe_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_addr        = probe_reg;
        wr_en          = 1'b0;
        done           = 1'b0;
        done_res       = res_reg;
        mid_w          = CW'(probe_reg);
        lo_w           = lo_reg;
        hi_w           = hi_reg;
        span_w         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.kind)
                        sls_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                            order_next = 1'b1;
                            last_next  = '0;
                            done       = 1'b1;
                            done_res   = pack(sls_pkg::ST_ACCEPTED, '0, 1'b1, '0);
                        end
                        sls_pkg::KIND_APPEND:
                        begin
                            done = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                done_res = pack(sls_pkg::ST_FULL, '0, order_reg, count_reg);
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (count_reg != '0 && $signed(req.value) < last_reg)
                                begin
                                    order_next = 1'b0;
                                end
                                last_next  = req.value;
                                count_next = count_reg + 1'b1;
                                done_res   = pack(sls_pkg::ST_ACCEPTED, '0, order_next,
                                                  count_next);
                            end
                        end
                        sls_pkg::KIND_SEARCH:
                        begin
                            key_next = req.value;
                            if (req.method == sls_pkg::METHOD_BINARY && !order_reg)
                            begin
                                done     = 1'b1;
                                done_res = pack(sls_pkg::ST_UNSORTED, '0, order_reg, count_reg);
                            end
                            else if (count_reg == '0)
                            begin
                                done     = 1'b1;
                                done_res = pack(sls_pkg::ST_NOT_FOUND, '0, order_reg, count_reg);
                            end
                            else if (req.method == sls_pkg::METHOD_LINEAR)
                            begin
                                probe_next = '0;
                                rd_addr    = '0;
                                state_next = S_LIN;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                probe_next = AW'(count_reg >> 1);
                                rd_addr    = AW'(count_reg >> 1);
                                state_next = S_BIN;
                            end
                        end
                        default:
                        begin
                            done     = 1'b1;
                            done_res = pack(sls_pkg::ST_ACCEPTED, '0, order_reg, count_reg);
                        end
                    endcase
                end
            end
            S_LIN:
            begin
                if (rd_data_reg == key_reg)
                begin
                    done     = 1'b1;
                    done_res = pack(sls_pkg::ST_FOUND, probe_reg, order_reg, count_reg);
                end
                else if (CW'(probe_reg) + 1'b1 == count_reg)
                begin
                    done     = 1'b1;
                    done_res = pack(sls_pkg::ST_NOT_FOUND, '0, order_reg, count_reg);
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    rd_addr    = probe_reg + 1'b1;
                end
            end
            S_BIN:
            begin
                if (rd_data_reg == key_reg)
                begin
                    done     = 1'b1;
                    done_res = pack(sls_pkg::ST_FOUND, probe_reg, order_reg, count_reg);
                end
                else
                begin
                    if (rd_data_reg < key_reg)
                    begin
                        lo_w = mid_w + 1'b1;
                    end
                    else
                    begin
                        hi_w = mid_w;
                    end
                    lo_next = lo_w;
                    hi_next = hi_w;
                    if (lo_w >= hi_w)
                    begin
                        done     = 1'b1;
                        done_res = pack(sls_pkg::ST_NOT_FOUND, '0, order_reg, count_reg);
                    end
                    else
                    begin
                        span_w     = (hi_w - lo_w) >> 1;
                        probe_next = AW'(lo_w + span_w);
                        rd_addr    = AW'(lo_w + span_w);
                    end
                end
            end
            S_EMIT:
            begin
                done     = 1'b1;
                done_res = res_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done)
        begin
            if (slot_free)
            begin
                rsp_next       = done_res;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = done_res;
                state_next = S_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            order_reg     <= 1'b1;
            last_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            order_reg     <= order_next;
            last_reg      <= last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        probe_reg <= probe_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(count_reg)] <= req.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

FILE: rtl/sls_check.sv
module sls_check #(
    parameter int DEPTH = 32
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input sls_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input sls_pkg::rsp_t rsp
);

    localparam int NW = $clog2(DEPTH + 1) + 6;
    localparam logic [NW-1:0] DEPTH_W = NW'(DEPTH);

    // held beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp beat changed while stalled");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != sls_pkg::ST_FOUND |-> rsp.index == 5'd0)
        else $error("nonzero index without a match");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == sls_pkg::ST_FULL |-> rsp.count == DEPTH_W[5:0])
        else $error("full status with list not full");

    a_unsorted_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == sls_pkg::ST_UNSORTED |-> !rsp.is_sorted)
        else $error("unsorted status with sorted flag set");

endmodule

bind sorted_list_search sls_check #(.DEPTH(DEPTH)) u_sls_check (.*);
